// ===== design/mstk_pkg.sv =====
package mstk_pkg;

    typedef struct packed {
        logic [6:0]  from_vertex;
        logic [6:0]  to_vertex;
        logic signed [15:0] weight;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [6:0]  from_vertex_out;
        logic [6:0]  to_vertex_out;
        logic signed [15:0] weight_out;
        logic [6:0]  root_first;
        logic [6:0]  root_second;
        logic        taken;
        logic        bad_vertex;
        logic        dropped_any;
        logic        last_out;
    } t_out;

    localparam int WEIGHT_BITS = 16;

endpackage

// ===== design/minimum_spanning_tree_kruskal_unit.sv =====
// Busy stays low while edges load; after the last beat every parent table entry,
// 0 to MAX_VERTICES, is set to its own index. Each stored edge then takes a selection
// pass over the stored edges, a root walk along the parent links from each end (cut
// short for a bad edge) and an emit state.
// Reset clears the edge count, the overflow flag and sets vertex_count to 64.
// Results appear as one-cycle strobes, registered from the emit state; the receiver cannot stall.
module minimum_spanning_tree_kruskal_unit
    import mstk_pkg::*;
#(
    parameter int MAX_EDGES    = 64,
    parameter int MAX_VERTICES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in        i_item,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    output logic       o_strobe,
    output t_out       o_result
);

    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int PW = $clog2(MAX_VERTICES + 1);

    localparam logic [2:0] S_LOAD = 3'd0, S_INIT = 3'd1, S_SCAN = 3'd2,
                           S_WALK = 3'd3, S_EMIT = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic         r_ovf, n_ovf;
    logic [6:0]   r_vcnt;

    logic [29:0]  r_mem [MAX_EDGES];
    logic [EW-1:0] r_mem_addr;
    logic [29:0]  r_mem_q;

    logic [6:0]   r_par [MAX_VERTICES + 1];
    logic [6:0]   r_par_q;
    logic [MAX_EDGES-1:0] r_done, n_done;

    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [EW-1:0] r_best, n_best;
    logic         r_have, n_have;
    logic [29:0]  r_bestv, n_bestv;
    logic [PW-1:0] r_k, n_k;
    logic [6:0]   r_ra, n_ra, r_rb, n_rb;
    logic [6:0]   r_walk, n_walk;
    logic         r_side, n_side;
    logic [29:0]  r_edge, n_edge;
    logic         r_strobe, n_strobe;
    t_out         r_out, n_out;

    logic         in_acc;
    logic [EW-1:0] rd_addr;
    logic [6:0]   cnt_eff;
    logic signed [WEIGHT_BITS-1:0] w_cand, w_best;
    logic [6:0]   e_from, e_to;
    logic         e_bad;
    logic [6:0]   par_q;
    logic         par_we;
    logic [PW-1:0] par_wa;
    logic [6:0]   par_wd;

    assign in_acc  = start && !busy;
    assign busy    = (r_state != S_LOAD);
    assign cnt_eff = (r_vcnt > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : r_vcnt;
    assign w_cand  = r_mem_q[WEIGHT_BITS-1:0];
    assign w_best  = r_bestv[WEIGHT_BITS-1:0];
    assign e_from  = r_edge[29:23];
    assign e_to    = r_edge[22:16];
    assign e_bad   = (e_from == 7'd0) || (e_from > cnt_eff) ||
                     (e_to == 7'd0) || (e_to > cnt_eff);
    assign par_q   = (r_walk <= 7'(MAX_VERTICES)) ? r_par_q : r_walk;
    assign rd_addr = r_j[EW-1:0];

    always_ff @(posedge i_clk) begin
        if (in_acc && r_total < CW'(MAX_EDGES)) begin
            r_mem[r_total[EW-1:0]] <= {i_item.from_vertex, i_item.to_vertex, i_item.weight};
        end
        r_mem_q    <= r_mem[rd_addr];
        r_mem_addr <= rd_addr;
        if (par_we) begin
            r_par[par_wa] <= par_wd;
        end
        r_par_q <= r_par[PW'(n_walk)];
    end

    always_comb begin
        n_state = r_state; n_total = r_total; n_ovf = r_ovf; n_done = r_done;
        n_i = r_i; n_j = r_j; n_best = r_best; n_have = r_have; n_bestv = r_bestv;
        n_k = r_k; n_ra = r_ra; n_rb = r_rb; n_walk = r_walk; n_side = r_side;
        n_edge = r_edge; n_strobe = 1'b0; n_out = r_out;
        par_we = 1'b0; par_wa = r_k; par_wd = 7'(r_k);
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_total < CW'(MAX_EDGES)) begin
                        n_total = r_total + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last) begin
                        n_i = '0; n_k = '0; n_done = '0;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                par_we = 1'b1;
                n_k = r_k + 1'b1;
                if (r_k == PW'(MAX_VERTICES)) begin
                    n_j = '0; n_have = 1'b0; n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // r_j counts issued reads; data for address r_j-1 arrives now.
                if (r_j != '0 && !r_done[r_mem_addr] &&
                    (!r_have || w_cand < w_best)) begin
                    n_have = 1'b1; n_best = r_mem_addr; n_bestv = r_mem_q;
                end
                if (r_j == r_total) begin
                    n_done[n_best] = 1'b1;
                    n_have = 1'b0; n_j = '0;
                    n_edge = n_bestv;
                    n_walk = n_bestv[29:23];
                    n_side = 1'b0;
                    n_state = S_WALK;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_WALK: begin
                if (e_bad) begin
                    n_ra = '0; n_rb = '0; n_state = S_EMIT;
                end else if (par_q != r_walk) begin
                    n_walk = par_q;
                end else if (!r_side) begin
                    n_ra = r_walk; n_side = 1'b1; n_walk = e_to;
                end else begin
                    n_rb = r_walk; n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_out.from_vertex_out = e_from;
                n_out.to_vertex_out   = e_to;
                n_out.weight_out      = r_edge[15:0];
                n_out.root_first      = r_ra;
                n_out.root_second     = r_rb;
                n_out.taken           = !e_bad && (r_ra != r_rb);
                n_out.bad_vertex      = e_bad;
                n_out.dropped_any     = r_ovf;
                n_out.last_out        = (r_i + 1'b1 == r_total);
                if (!e_bad && r_ra != r_rb) begin
                    par_we = 1'b1; par_wa = PW'(r_rb); par_wd = r_ra;
                end
                n_i = r_i + 1'b1;
                n_j = '0; n_have = 1'b0;
                if (n_i == r_total) begin
                    n_state = S_LOAD; n_total = '0; n_ovf = 1'b0;
                end else begin
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_total <= '0; r_ovf <= 1'b0; r_vcnt <= 7'd64;
            r_strobe <= 1'b0; r_done <= '0;
        end else begin
            r_state <= n_state; r_total <= n_total; r_ovf <= n_ovf;
            r_strobe <= n_strobe; r_done <= n_done;
            if (i_cfg_we) begin
                r_vcnt <= i_cfg_data;
            end
        end
        r_i <= n_i; r_j <= n_j; r_best <= n_best; r_have <= n_have; r_bestv <= n_bestv;
        r_k <= n_k; r_ra <= n_ra; r_rb <= n_rb; r_walk <= n_walk; r_side <= n_side;
        r_edge <= n_edge; r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && !$past(r_state == S_EMIT)) |-> !o_strobe)
        else $error("result beat outside a run");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_EDGES)) else $error("edge count overflow");
    a_taken_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.taken && o_result.bad_vertex))
        else $error("bad edge taken");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb
    import mstk_pkg::*;
;

    localparam int EDGE_CAP = 64;
    localparam int VTX_CAP  = 64;

    class mst_scoreboard;
        logic [6:0]  edge_from [$];
        logic [6:0]  edge_to [$];
        logic [15:0] edge_w [$];
        logic        overflow;
        logic [6:0]  vtx_count;
        t_out        expected_edges [$];
        int          mismatches;
        int          results_seen;
        int          graphs_seen;

        function new();
            overflow = 1'b0;
            vtx_count = 7'd64;
            mismatches = 0;
            results_seen = 0;
            graphs_seen = 0;
        endfunction

        function void note_edge(t_in it);
            int n;
            int order [$];
            int j;
            int cnt;
            logic [6:0] parent [0:VTX_CAP];
            logic [6:0] ra;
            logic [6:0] rb;
            logic bad;
            int steps;
            t_out r;
            if (edge_from.size() < EDGE_CAP) begin
                edge_from.insert(edge_from.size(), it.from_vertex);
                edge_to.insert(edge_to.size(), it.to_vertex);
                edge_w.insert(edge_w.size(), it.weight);
            end else begin
                overflow = 1'b1;
            end
            if (!it.last) return;
            n = edge_from.size();
            for (int i = 0; i < n; i++) begin
                j = order.size();
                while (j > 0 && $signed(edge_w[order[j - 1]]) > $signed(edge_w[i])) j--;
                order.insert(j, i);
            end
            cnt = (vtx_count > VTX_CAP) ? VTX_CAP : vtx_count;
            for (int i = 0; i <= VTX_CAP; i++) parent[i] = i[6:0];
            for (int i = 0; i < n; i++) begin
                ra = '0;
                rb = '0;
                r = '0;
                bad = edge_from[order[i]] == 0 || edge_from[order[i]] > cnt ||
                      edge_to[order[i]] == 0 || edge_to[order[i]] > cnt;
                if (!bad) begin
                    ra = edge_from[order[i]];
                    steps = 0;
                    while (steps < VTX_CAP && parent[ra] != ra) begin
                        ra = parent[ra];
                        steps++;
                    end
                    rb = edge_to[order[i]];
                    steps = 0;
                    while (steps < VTX_CAP && parent[rb] != rb) begin
                        rb = parent[rb];
                        steps++;
                    end
                    if (ra != rb) begin
                        parent[rb] = ra;
                        r.taken = 1'b1;
                    end
                end
                r.from_vertex_out = edge_from[order[i]];
                r.to_vertex_out = edge_to[order[i]];
                r.weight_out = edge_w[order[i]];
                r.root_first = ra;
                r.root_second = rb;
                r.bad_vertex = bad;
                r.dropped_any = overflow;
                r.last_out = (i == n - 1);
                expected_edges.insert(expected_edges.size(), r);
            end
            edge_from.delete();
            edge_to.delete();
            edge_w.delete();
            overflow = 1'b0;
            graphs_seen++;
        endfunction

        function void check_edge(t_out got);
            t_out exp;
            results_seen++;
            if (expected_edges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat: %p", got);
                return;
            end
            exp = expected_edges.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp, got);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in        i_item = '0;
    logic       i_cfg_we = 1'b0;
    logic [6:0] i_cfg_data = '0;
    logic       o_strobe;
    t_out       o_result;

    mst_scoreboard sb = new();
    int items_sent = 0;

    minimum_spanning_tree_kruskal_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_edge(o_result);
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    task automatic send_edge(input logic [6:0] fv, input logic [6:0] tv,
                             input logic [15:0] w, input logic lst, input bit gaps);
        t_in it;
        int n;
        it.from_vertex = fv;
        it.to_vertex = tv;
        it.weight = w;
        it.last = lst;
        n = 0;
        if (gaps && $urandom_range(0, 2) == 0) n = gap_len();
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_item <= it;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_edge(it);
        items_sent++;
        if (lst) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (sb.expected_edges.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_vertices(input logic [6:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.vtx_count = v;
    endtask

    task automatic random_graph(input int n_edges, input int vmax, input bit gaps);
        logic [6:0] fv;
        logic [6:0] tv;
        logic [15:0] w;
        for (int i = 0; i < n_edges; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                fv = 7'($urandom_range(0, 127));
                tv = 7'($urandom_range(0, 127));
            end else begin
                fv = 7'($urandom_range(1, vmax));
                tv = 7'($urandom_range(1, vmax));
            end
            case ($urandom_range(0, 3))
                0: w = 16'($urandom_range(0, 3));
                1: w = 16'h8000 | 16'($urandom_range(0, 1));
                2: w = 16'h7FFF - 16'($urandom_range(0, 1));
                default: w = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_edge(fv, tv, w, i == n_edges - 1, gaps);
        end
    endtask

    initial begin
        int sz;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_edge(7'd64, 7'd1, 16'h7FFF, 1'b0, 1'b0);
        send_edge(7'd1, 7'd2, 16'h8000, 1'b0, 1'b0);
        send_edge(7'd2, 7'd1, 16'h8000, 1'b0, 1'b0);
        send_edge(7'd0, 7'd3, 16'h0000, 1'b0, 1'b0);
        send_edge(7'd3, 7'd127, 16'hFFFF, 1'b0, 1'b0);
        send_edge(7'd5, 7'd5, 16'h0001, 1'b0, 1'b0);
        send_edge(7'd64, 7'd2, 16'h5555, 1'b1, 1'b0);
        send_edge(7'd7, 7'd9, 16'hAAAA, 1'b1, 1'b0);
        drain();
        set_vertices(7'd1);
        send_edge(7'd1, 7'd1, 16'h0003, 1'b0, 1'b0);
        send_edge(7'd1, 7'd2, 16'h0002, 1'b1, 1'b0);
        set_vertices(7'd0);
        send_edge(7'd1, 7'd1, 16'h0000, 1'b1, 1'b0);
        set_vertices(7'd127);
        random_graph(3, 127, 1'b0);

        // A full store plus overflow, also on the final beat.
        set_vertices(7'd64);
        random_graph(66, 64, 1'b1);
        set_vertices(7'd8);
        random_graph(70, 12, 1'b0);

        set_vertices(7'd64);
        while (items_sent < 260) begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
            if (sz > 260 - items_sent) sz = 260 - items_sent;
            if ($urandom_range(0, 5) == 0)
                set_vertices($urandom_range(0, 3) == 0 ? 7'd64
                             : 7'($urandom_range(2, 16)));
            random_graph(sz, (sb.vtx_count > 64 || sb.vtx_count == 0) ? 64
                         : sb.vtx_count + 1, 1'b1);
        end
        drain();

        $display("Sent %0d edge beats in %0d graphs; checked %0d result beats.",
                 items_sent, sb.graphs_seen, sb.results_seen);
        if (sb.mismatches == 0 && sb.expected_edges.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing.",
                     sb.mismatches, sb.expected_edges.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Timed out.");
        $display("== FAIL ==");
        $finish;
    end

endmodule
